// ===== rtl/core/gjpc_pkg.sv =====
package gjpc_pkg;

    localparam int JUMP_W           = 8;
    localparam int SIDE_W           = 8;
    localparam int COUNT_W          = 64;
    localparam int MAX_SIDE_DEFAULT = 128;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 8'd128;

    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

// ===== rtl/core/gjpc_channels.sv =====
interface gjpc_cell_if;
    logic                        valid;
    logic                        ready;
    logic [gjpc_pkg::JUMP_W-1:0] cell_jump;

    modport source (output valid, output cell_jump, input ready);
    modport sink (input valid, input cell_jump, output ready);
endinterface

interface gjpc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [gjpc_pkg::SIDE_W-1:0] grid_side;

    modport source (output valid, output grid_side, input ready);
    modport sink (input valid, input grid_side, output ready);
endinterface

interface gjpc_count_if;
    logic                         valid;
    logic                         ready;
    logic [gjpc_pkg::COUNT_W-1:0] path_count;

    modport source (output valid, output path_count, input ready);
    modport sink (input valid, input path_count, output ready);
endinterface

// ===== rtl/core/gjpc_path_ram.sv =====
module gjpc_path_ram #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14,
    parameter int DW    = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] mem_data_reg;
    logic [DW-1:0] byp_data_reg;
    logic          byp_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_data_reg <= mem[rd_addr];
        byp_data_reg <= wr_data;
    end

    // A read of the entry written in the same cycle returns the new word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            byp_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : mem_data_reg;

endmodule

// ===== rtl/core/gjpc_seq.sv =====
module gjpc_seq #(
    parameter int MAX_SIDE = gjpc_pkg::MAX_SIDE_DEFAULT,
    parameter int DEPTH    = MAX_SIDE * MAX_SIDE,
    parameter int AW       = $clog2(MAX_SIDE * MAX_SIDE)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cell_valid,
    input  logic [gjpc_pkg::JUMP_W-1:0]         cell_jump,
    output logic                                cell_ready,
    input  logic                                cfg_valid,
    input  logic [gjpc_pkg::SIDE_W-1:0]         cfg_data,
    output logic                                cfg_ready,
    input  logic                                out_busy,
    output logic [AW-1:0]                       rd_addr,
    input  logic [gjpc_pkg::COUNT_W-1:0]        rd_data,
    output logic                                wr_en,
    output logic [AW-1:0]                       wr_addr,
    output logic [gjpc_pkg::COUNT_W-1:0]        wr_data,
    output gjpc_pkg::result_t                   res
);

    localparam int PW = $clog2(MAX_SIDE);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int EW = ((PW > gjpc_pkg::JUMP_W) ? PW : gjpc_pkg::JUMP_W) + 1;
    localparam int CW = gjpc_pkg::COUNT_W;

    function automatic logic [AW-1:0] cell_addr(input logic [PW-1:0] r, input logic [PW-1:0] c);
        cell_addr = AW'(int'(r) * MAX_SIDE + int'(c));
    endfunction

    logic [gjpc_pkg::SIDE_W-1:0] side_reg;
    logic [PW-1:0]               row_reg;
    logic [PW-1:0]               col_reg;
    logic                        clear_reg;
    logic [AW-1:0]               clr_addr_reg;

    logic                        s1_reg;
    logic                        s2_reg;
    logic                        s3_reg;
    logic [AW-1:0]               addr_cur_reg;
    logic [AW-1:0]               addr_dn_reg;
    logic [AW-1:0]               addr_rt_reg;
    logic                        en_dn_reg;
    logic                        en_rt_reg;
    logic                        first_reg;
    logic                        last_reg;
    logic [CW-1:0]               cur_reg;

    logic [SW-1:0]               side_use;
    logic [SW-1:0]               side_last;
    logic                        row_end;
    logic                        col_end;
    logic                        last_pos;
    logic                        first_pos;
    logic [EW-1:0]               r_dn;
    logic [EW-1:0]               c_rt;
    logic                        jump_nz;
    logic                        accept;
    logic [CW-1:0]               cur_val;
    logic [CW-1:0]               sum;

    always_comb
    begin
        if (side_reg == '0)
        begin
            side_use = SW'(1);
        end
        else if (int'(side_reg) > MAX_SIDE)
        begin
            side_use = SW'(MAX_SIDE);
        end
        else
        begin
            side_use = SW'(side_reg);
        end
    end

    assign side_last = side_use - SW'(1);
    assign row_end   = (SW'(row_reg) == side_last);
    assign col_end   = (SW'(col_reg) == side_last);
    assign last_pos  = row_end && col_end;
    assign first_pos = (row_reg == '0) && (col_reg == '0);
    assign r_dn      = EW'(row_reg) + EW'(cell_jump);
    assign c_rt      = EW'(col_reg) + EW'(cell_jump);
    assign jump_nz   = (cell_jump != '0);

    assign cell_ready = !clear_reg && !s1_reg && !s2_reg && !cfg_valid
                        && !(last_pos && out_busy);
    assign cfg_ready  = !s1_reg && !s2_reg && !s3_reg;
    assign accept     = cell_valid && cell_ready;

    assign cur_val = first_reg ? CW'(1) : rd_data;
    assign sum     = rd_data + cur_reg;

    always_comb
    begin
        if (s1_reg)
        begin
            rd_addr = addr_dn_reg;
        end
        else if (s2_reg)
        begin
            rd_addr = addr_rt_reg;
        end
        else
        begin
            rd_addr = cell_addr(row_reg, col_reg);
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_addr_reg;
        wr_data = '0;
        if (s1_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = addr_cur_reg;
        end
        else if (s2_reg)
        begin
            wr_en   = en_dn_reg;
            wr_addr = addr_dn_reg;
            wr_data = sum;
        end
        else if (s3_reg)
        begin
            wr_en   = en_rt_reg;
            wr_addr = addr_rt_reg;
            wr_data = sum;
        end
        else if (clear_reg)
        begin
            wr_en = 1'b1;
        end
    end

    assign res.valid = s1_reg && last_reg;
    assign res.count = cur_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg     <= gjpc_pkg::SIDE_RESET;
            row_reg      <= '0;
            col_reg      <= '0;
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
            s1_reg       <= 1'b0;
            s2_reg       <= 1'b0;
            s3_reg       <= 1'b0;
        end
        else
        begin
            s1_reg <= accept;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            if (cfg_valid && cfg_ready)
            begin
                side_reg     <= cfg_data;
                row_reg      <= '0;
                col_reg      <= '0;
                clear_reg    <= 1'b1;
                clr_addr_reg <= '0;
            end
            else
            begin
                if (clear_reg)
                begin
                    if (clr_addr_reg == AW'(DEPTH - 1))
                    begin
                        clear_reg <= 1'b0;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + AW'(1);
                    end
                end
                if (accept)
                begin
                    if (last_pos)
                    begin
                        row_reg <= '0;
                        col_reg <= '0;
                    end
                    else if (col_end)
                    begin
                        row_reg <= row_reg + PW'(1);
                        col_reg <= '0;
                    end
                    else
                    begin
                        col_reg <= col_reg + PW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_cur_reg <= cell_addr(row_reg, col_reg);
            addr_dn_reg  <= cell_addr(PW'(r_dn), col_reg);
            addr_rt_reg  <= cell_addr(row_reg, PW'(c_rt));
            en_dn_reg    <= !last_pos && jump_nz && (r_dn < EW'(side_use));
            en_rt_reg    <= !last_pos && jump_nz && (c_rt < EW'(side_use));
            first_reg    <= first_pos;
            last_reg     <= last_pos;
        end
        if (s1_reg)
        begin
            cur_reg <= cur_val;
        end
    end

endmodule

// ===== rtl/core/grid_jump_path_counter_top.sv =====
// Counts the paths from the top-left to the bottom-right cell of a square grid whose cells
// arrive as jump lengths in row-major order, one word per cell. Each cell makes three accesses
// (its own entry, the entry one jump below and the entry one jump to the right) on the
// single read port of the path store, so a new cell is taken only after the previous one
// has made its three reads. The count for the bottom-right cell is formed when that cell's
// own entry is read back and waits in an output register until it is taken; a bottom-right
// cell is held off while an earlier count still waits there. A write of grid_side is held
// off while a cell is in flight. After reset and after every write of grid_side the store
// is cleared entry by entry, during which no cell is taken.
module grid_jump_path_counter_top #(
    parameter int MAX_SIDE = gjpc_pkg::MAX_SIDE_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    gjpc_cell_if.sink    cells,
    gjpc_cfg_if.sink     cfg,
    gjpc_count_if.source result
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int CW    = gjpc_pkg::COUNT_W;

    logic [AW-1:0]     rd_addr;
    logic [CW-1:0]     rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CW-1:0]     wr_data;
    gjpc_pkg::result_t res;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CW-1:0]     out_count_reg;

    gjpc_seq #(
        .MAX_SIDE (MAX_SIDE),
        .DEPTH    (DEPTH),
        .AW       (AW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cells.valid),
        .cell_jump  (cells.cell_jump),
        .cell_ready (cells.ready),
        .cfg_valid  (cfg.valid),
        .cfg_data   (cfg.grid_side),
        .cfg_ready  (cfg.ready),
        .out_busy   (out_valid_reg),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .res        (res)
    );

    gjpc_path_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (CW)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res.valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            out_count_reg <= res.count;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.path_count = out_count_reg;

endmodule

// ===== rtl/core/gjpc_checker.sv =====
module gjpc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cell_valid,
    input logic                         cell_ready,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic [gjpc_pkg::COUNT_W-1:0] result_path_count
);

    // A waiting result word must hold until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_path_count))
    else $error("result word changed or dropped while stalled");

    // After a cell is taken, the cell port stays closed while that cell still reads the path store.
    a_cell_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && cell_ready |=> !cell_ready ##1 !cell_ready)
    else $error("cell taken before the previous one left the store");

    // A new grid side starts a clearing pass that blocks cells.
    a_clear_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !cell_ready)
    else $error("cell port open right after a grid side write");

    // A rising result must trace back to a taken cell, through the sequencer's stage register and the output register.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(cell_valid && cell_ready, 2))
    else $error("result appeared without a matching cell");

endmodule

bind grid_jump_path_counter_top gjpc_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cell_valid        (cells.valid),
    .cell_ready        (cells.ready),
    .cfg_valid         (cfg.valid),
    .cfg_ready         (cfg.ready),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_path_count (result.path_count)
);
